// ===== hdl/kcalc_pkg.sv =====
`default_nettype none

package kcalc_pkg;

  // Default operand width and the fixed width of the result field
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RESULT_WIDTH    = 32;

  // Key codes (ASCII)
  localparam logic [7:0] KEY_PLUS   = 8'h2B;
  localparam logic [7:0] KEY_MINUS  = 8'h2D;
  localparam logic [7:0] KEY_TIMES  = 8'h78;
  localparam logic [7:0] KEY_DIVIDE = 8'h2F;
  localparam logic [7:0] KEY_EQUALS = 8'h3D;
  localparam logic [7:0] KEY_CLEAR  = 8'h63;
  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_NINE   = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_ADDSUB,
    ALU_MUL,
    ALU_DIVPREP,
    ALU_DIV,
    ALU_FIX,
    ALU_DONE
  } alu_state_t;

  // Operand entry controls, one key per cycle while the input is not stalled
  typedef struct packed {
    logic       clear;
    logic       set_neg;
    logic       digit_en;
    logic [3:0] digit;
    logic       take;
  } entry_ctl_t;

  // Request to the arithmetic unit
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  // Status back from the arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
    logic dz;
  } alu_stat_t;

endpackage

`default_nettype wire

// ===== hdl/keypad_calculator_fsm.sv =====
`default_nettype none

// Four-function keypad calculator. Feed one ASCII key per request on the input
// channel: digits build an operand, a leading '-' makes it negative, 'c' drops
// the operand being typed, an operator key (+ - x /) closes the first operand
// and '=' closes the second and produces one result request carrying the
// wrapped two's complement result and a divide-by-zero flag (result zero).
// Every key except '=' in the second phase is taken at once. After '='
// the input stalls while the shared shift-add / restoring-divide unit works:
// add and subtract in its add/subtract state, multiply one multiplier bit
// per cycle, divide one quotient bit per cycle plus magnitude and sign
// fix-up steps. The input is also held while a finished result waits for a
// free output register.
module keypad_calculator_fsm
  import kcalc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      key_code,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [RESULT_WIDTH-1:0]       result_value,
  output logic                                 divide_by_zero
);

  logic                   second_phase;
  logic [VALUE_WIDTH-1:0] first_operand;
  op_t                    pending_op;

  logic                   accept;
  logic                   is_digit;
  logic                   is_op;
  op_t                    key_op;
  logic                   started;
  logic [VALUE_WIDTH-1:0] taken;
  logic [VALUE_WIDTH-1:0] alu_result;
  logic                   out_free;
  entry_ctl_t             ectl;
  alu_req_t               areq;
  alu_stat_t              astat;

  assign in_stall = astat.busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Decode the key
  assign is_digit = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
  always_comb begin
    is_op  = 1'b1;
    key_op = OP_ADD;
    case (key_code)
      KEY_PLUS:   key_op = OP_ADD;
      KEY_MINUS:  key_op = OP_SUB;
      KEY_TIMES:  key_op = OP_MUL;
      KEY_DIVIDE: key_op = OP_DIV;
      default:    is_op = 1'b0;
    endcase
  end

  // Key handling, in priority order
  always_comb begin
    ectl          = '0;
    ectl.digit    = 4'(key_code - KEY_ZERO);
    areq.start    = 1'b0;
    areq.op       = pending_op;
    if (accept) begin
      if (key_code == KEY_CLEAR) begin
        ectl.clear = 1'b1;
      end else if ((key_code == KEY_MINUS) && !started) begin
        ectl.set_neg = 1'b1;
      end else if (is_digit) begin
        ectl.digit_en = 1'b1;
      end else if (!second_phase) begin
        ectl.take = is_op;
      end else if (key_code == KEY_EQUALS) begin
        ectl.take  = 1'b1;
        areq.start = 1'b1;
      end
    end
  end

  // Phase, first operand and pending operation
  always_ff @(posedge clk) begin
    if (rst) begin
      second_phase  <= 1'b0;
      first_operand <= '0;
      pending_op    <= OP_ADD;
    end else if (ectl.take) begin
      if (!second_phase) begin
        first_operand <= taken;
        pending_op    <= key_op;
        second_phase  <= 1'b1;
      end else begin
        second_phase <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (astat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (astat.done) begin
      result_value   <= RESULT_WIDTH'($signed(alu_result));
      divide_by_zero <= astat.dz;
    end
  end

  kcalc_entry #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_entry (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ectl),
    .started (started),
    .taken   (taken)
  );

  kcalc_alu #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .req      (areq),
    .a        (first_operand),
    .b        (taken),
    .out_free (out_free),
    .stat     (astat),
    .result   (alu_result)
  );

endmodule

`default_nettype wire

// ===== hdl/kcalc_entry.sv =====
`default_nettype none

module kcalc_entry
  import kcalc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire entry_ctl_t             ctl,
  output logic                        started,
  output logic [VALUE_WIDTH-1:0]      taken
);

  logic [VALUE_WIDTH-1:0] entry_value;
  logic [VALUE_WIDTH-1:0] entry_value_next;
  logic                   entry_negative;

  // Signed operand as it leaves the entry register
  assign taken = entry_negative ? (VALUE_WIDTH'(0) - entry_value) : entry_value;

  // Shift in one decimal digit: value * 8 + value * 2 + digit, wrapping
  assign entry_value_next = {entry_value[VALUE_WIDTH-4:0], 3'b000}
                          + {entry_value[VALUE_WIDTH-2:0], 1'b0}
                          + VALUE_WIDTH'(ctl.digit);

  // Hold, extend or drop the operand being typed
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_value    <= '0;
      entry_negative <= 1'b0;
      started        <= 1'b0;
    end else if (ctl.clear || ctl.take) begin
      entry_value    <= '0;
      entry_negative <= 1'b0;
      started        <= 1'b0;
    end else if (ctl.set_neg) begin
      entry_negative <= 1'b1;
      started        <= 1'b1;
    end else if (ctl.digit_en) begin
      entry_value <= entry_value_next;
      started     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kcalc_alu.sv =====
`default_nettype none

module kcalc_alu
  import kcalc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire alu_req_t               req,
  input  wire logic [VALUE_WIDTH-1:0] a,
  input  wire logic [VALUE_WIDTH-1:0] b,
  input  wire logic                   out_free,
  output alu_stat_t                   stat,
  output logic [VALUE_WIDTH-1:0]      result
);

  localparam int CW = $clog2(VALUE_WIDTH);

  alu_state_t             state;
  alu_state_t             state_next;
  op_t                    op_r;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] opa;
  logic [VALUE_WIDTH-1:0] opb;
  logic [CW-1:0]          cnt;
  logic                   neg_q;
  logic                   dz;
  logic [VALUE_WIDTH-1:0] rem_sh;
  logic                   rem_ge;

  // Restoring divide step: bring down the next dividend bit
  assign rem_sh = {acc[VALUE_WIDTH-2:0], opa[VALUE_WIDTH-1]};
  assign rem_ge = (rem_sh >= opb);

  assign result    = acc;
  assign stat.busy = (state != ALU_IDLE);
  assign stat.done = (state == ALU_DONE) && out_free;
  assign stat.dz   = dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ALU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ALU_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL:  state_next = ALU_MUL;
            OP_DIV:  state_next = ALU_DIVPREP;
            default: state_next = ALU_ADDSUB;
          endcase
        end
      end
      ALU_ADDSUB:  state_next = ALU_DONE;
      ALU_MUL:     if (cnt == '0) state_next = ALU_DONE;
      ALU_DIVPREP: state_next = (opb == '0) ? ALU_DONE : ALU_DIV;
      ALU_DIV:     if (cnt == '0) state_next = ALU_FIX;
      ALU_FIX:     state_next = ALU_DONE;
      ALU_DONE:    if (out_free) state_next = ALU_IDLE;
      default:     state_next = ALU_IDLE;
    endcase
  end

  // Datapath: one multiplier or quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state)
      ALU_IDLE: begin
        if (req.start) begin
          opa  <= a;
          opb  <= b;
          op_r <= req.op;
          acc  <= '0;
          cnt  <= CW'(VALUE_WIDTH - 1);
          dz   <= 1'b0;
        end
      end
      ALU_ADDSUB: begin
        acc <= (op_r == OP_SUB) ? (opa - opb) : (opa + opb);
      end
      ALU_MUL: begin
        if (opb[0]) begin
          acc <= acc + opa;
        end
        opa <= {opa[VALUE_WIDTH-2:0], 1'b0};
        opb <= {1'b0, opb[VALUE_WIDTH-1:1]};
        cnt <= cnt - 1'b1;
      end
      ALU_DIVPREP: begin
        if (opb == '0) begin
          dz  <= 1'b1;
          acc <= '0;
        end else begin
          neg_q <= opa[VALUE_WIDTH-1] ^ opb[VALUE_WIDTH-1];
          opa   <= opa[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - opa) : opa;
          opb   <= opb[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - opb) : opb;
          acc   <= '0;
        end
      end
      ALU_DIV: begin
        acc <= rem_ge ? (rem_sh - opb) : rem_sh;
        opa <= {opa[VALUE_WIDTH-2:0], rem_ge};
        cnt <= cnt - 1'b1;
      end
      ALU_FIX: begin
        acc <= neg_q ? (VALUE_WIDTH'(0) - opa) : opa;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== test/keypad_calculator_fsm_test.sv =====
module keypad_calculator_fsm_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kcalc_pkg::*;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] value;
    logic                           dz;
  } result_t;

  // One key request; typed rows carry the result expected on their '='
  typedef struct packed {
    logic [7:0]                     key;
    logic                           typed;
    logic signed [RESULT_WIDTH-1:0] value;
    logic                           dz;
  } key_item_t;

  // Directed row: a run of keys, or one raw code when keys is empty
  typedef struct {
    string                          keys;
    logic [7:0]                     raw;
    bit                             typed;
    logic signed [RESULT_WIDTH-1:0] value;
    logic                           dz;
  } key_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     key_code = 8'h00;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [RESULT_WIDTH-1:0] result_value;
  logic                           divide_by_zero;

  keypad_calculator_fsm dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .key_code       (key_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .divide_by_zero (divide_by_zero)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Calculator state as the predictor sees it, at reset values
  logic        calc_second  = 1'b0;
  logic [31:0] calc_entry   = '0;
  logic        calc_neg     = 1'b0;
  logic        calc_started = 1'b0;
  logic [31:0] calc_first   = '0;
  op_t         calc_op      = OP_ADD;

  key_item_t key_plan[$];
  result_t   pending_results[$];
  key_row_t  directed_rows[8];
  logic [7:0] punct_keys[6] = '{KEY_PLUS, KEY_MINUS, KEY_TIMES, KEY_DIVIDE, KEY_EQUALS,
                                KEY_CLEAR};

  int send_idx        = 0;
  bit plan_done       = 1'b0;
  int gap_left        = 0;
  int burst_left      = 0;
  int results_checked = 0;
  int fault_count     = 0;
  bit hold_off        = 1'b0;
  int stall_window    = 0;
  int stall_rate      = 0;

  // Close the operand being typed: apply its sign and clear the entry
  function automatic logic [31:0] take_operand();
    logic [31:0] v;
    v = calc_neg ? -calc_entry : calc_entry;
    calc_entry   = '0;
    calc_neg     = 1'b0;
    calc_started = 1'b0;
    return v;
  endfunction

  // Advance the calculator by one key; return 1 when the key yields a result
  function automatic bit calc_key(input logic [7:0] k, output result_t r);
    logic [31:0] a, b, ma, mb, q;
    op_t         o;
    bit          is_op;
    r     = '0;
    is_op = 1'b1;
    case (k)
      KEY_PLUS:   o = OP_ADD;
      KEY_MINUS:  o = OP_SUB;
      KEY_TIMES:  o = OP_MUL;
      KEY_DIVIDE: o = OP_DIV;
      default: begin
        o     = OP_ADD;
        is_op = 1'b0;
      end
    endcase
    if (k == KEY_CLEAR) begin
      calc_entry   = '0;
      calc_neg     = 1'b0;
      calc_started = 1'b0;
      return 1'b0;
    end
    if (k == KEY_MINUS && !calc_started) begin
      calc_neg     = 1'b1;
      calc_started = 1'b1;
      return 1'b0;
    end
    if (k >= KEY_ZERO && k <= KEY_NINE) begin
      calc_entry   = calc_entry * 32'd10 + {24'd0, k - KEY_ZERO};
      calc_started = 1'b1;
      return 1'b0;
    end
    if (!calc_second) begin
      if (is_op) begin
        calc_first  = take_operand();
        calc_op     = o;
        calc_second = 1'b1;
      end
      return 1'b0;
    end
    if (k != KEY_EQUALS) return 1'b0;
    a = calc_first;
    b = take_operand();
    case (calc_op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      default: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else begin
          // truncate toward zero on magnitudes, then restore the sign
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q  = ma / mb;
          r.value = (a[31] != b[31]) ? -q : q;
        end
      end
    endcase
    calc_second = 1'b0;
    return 1'b1;
  endfunction

  task automatic plan_key(input logic [7:0] k);
    key_plan.push_back('{k, 1'b0, 32'sd0, 1'b0});
  endtask

  // Queue one operand: optional sign, mostly short digit runs, now and then a clear
  task automatic plan_operand();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) plan_key(KEY_MINUS);
    for (int i = 0; i < n; i++) plan_key(KEY_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 15) == 0) begin
      plan_key(KEY_CLEAR);
      plan_key(KEY_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Drive key requests in bursts with random gaps; predict on each accept
  always @(posedge clk) begin : key_driver
    result_t r;
    result_t typed_r;
    int      next_idx;
    next_idx = send_idx;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (calc_key(key_plan[send_idx].key, r)) begin
          if (key_plan[send_idx].typed) begin
            typed_r.value = key_plan[send_idx].value;
            typed_r.dz    = key_plan[send_idx].dz;
            pending_results.push_back(typed_r);
          end else begin
            pending_results.push_back(r);
          end
        end
        next_idx = send_idx + 1;
        if (next_idx == key_plan.size()) plan_done <= 1'b1;
      end
      send_idx <= next_idx;
      // hold a stalled request; otherwise pick the next step of the burst pattern
      if (!(in_valid && in_stall)) begin
        if (next_idx >= key_plan.size() || gap_left != 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1'b1;
          key_code <= key_plan[next_idx].key;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Stall the result side in windows of random density, some with no stall
  always @(posedge clk) begin
    if (stall_window == 0) begin
      stall_window <= $urandom_range(8, 64);
      stall_rate   <= $urandom_range(0, 3);
    end else begin
      stall_window <= stall_window - 1;
    end
    out_stall <= hold_off || (stall_rate != 0 && $urandom_range(0, 3) < stall_rate);
  end

  // Hold off results for a long stretch once, so the key side backs up
  initial begin
    while (results_checked < 60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked <= results_checked + 1;
      if (pending_results.size() == 0) begin
        if (fault_count < 10)
          $display("result with none pending: value=%0d dz=%0b", result_value,
                   divide_by_zero);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value || divide_by_zero !== want.dz) begin
          if (fault_count < 10)
            $display("result mismatch: expected value=%0d dz=%0b, got value=%0d dz=%0b",
                     want.value, want.dz, result_value, divide_by_zero);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("keypad_calculator_fsm regression: fail");
    $finish;
  end

  initial begin
    int counted;
    int start_sz;
    int n;
    directed_rows = '{
      '{"",                8'h00, 1'b0, 32'sd0, 1'b0},  // lowest code is ignored
      '{"",                8'hFF, 1'b0, 32'sd0, 1'b0},  // highest code is ignored
      '{"=",               8'h00, 1'b0, 32'sd0, 1'b0},  // equals with no operator yet
      // clear both phases, lone sign then minus operator, operator in second phase
      '{"-c--7xc8=",       8'h00, 1'b1, -32'sd8, 1'b0},
      // entry wraps to the most negative value, then divide by minus one
      '{"-6442450944/-1=", 8'h00, 1'b1, 32'sh8000_0000, 1'b0},
      '{"/0=",             8'h00, 1'b1, 32'sd0, 1'b1},  // divide by zero
      '{"+7=",             8'h00, 1'b0, 32'sd0, 1'b0},
      '{"12x-3=",          8'h00, 1'b0, 32'sd0, 1'b0}
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].keys.len() == 0) begin
        plan_key(directed_rows[i].raw);
      end else begin
        for (int j = 0; j < directed_rows[i].keys.len(); j++)
          plan_key(directed_rows[i].keys[j]);
      end
      if (directed_rows[i].typed) begin
        key_plan[key_plan.size()-1].typed = 1'b1;
        key_plan[key_plan.size()-1].value = directed_rows[i].value;
        key_plan[key_plan.size()-1].dz    = directed_rows[i].dz;
      end
    end

    // Random part: mostly full expressions, some noise codes and broken runs
    counted = 0;
    while (counted < 1850) begin
      start_sz = key_plan.size();
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) plan_key(8'($urandom_range(0, 255)));
        end
        1: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) < 10) plan_key(KEY_ZERO + 8'($urandom_range(0, 9)));
            else plan_key(punct_keys[$urandom_range(0, 5)]);
          end
        end
        default: begin
          plan_operand();
          plan_key(punct_keys[$urandom_range(0, 3)]);
          plan_operand();
          plan_key(KEY_EQUALS);
        end
      endcase
      counted += key_plan.size() - start_sz;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests sent, all results back, then let the unit settle
    while (!(plan_done && pending_results.size() == 0)) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("keypad_calculator_fsm regression: pass");
    end else begin
      $display("keypad_calculator_fsm regression: fail");
    end
    $finish;
  end

endmodule

// ===== keypad_calculator_fsm.f =====
hdl/kcalc_pkg.sv
hdl/kcalc_entry.sv
hdl/kcalc_alu.sv
hdl/keypad_calculator_fsm.sv
test/keypad_calculator_fsm_test.sv
